### rtl/core/shht_pkg.sv
package shht_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned HDR_WORDS = 20;
   localparam int unsigned CNT_W = 5;
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_ABOVE = 2'd1;
   localparam logic [1:0] STATUS_STALE = 2'd2;

   localparam logic [1:0] CSR_TARGET_Q0 = 2'd0;
   localparam logic [1:0] CSR_TARGET_Q1 = 2'd1;
   localparam logic [1:0] CSR_TARGET_Q2 = 2'd2;
   localparam logic [1:0] CSR_TARGET_Q3 = 2'd3;

   // Classified front-end entry handed to the hash engine.
   typedef struct packed {
      logic [WORD_W-1:0] word;   // already byte-reversed
      logic [CNT_W-1:0]  pos;    // header word position 0..19
      logic              abort;  // early last mark: drop share
      logic              stale;
   } entry_type;

   typedef logic [31:0] word_type;

   function automatic word_type sha_k(input logic [5:0] i);
      word_type k;
      case (i)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type sha_iv(input logic [2:0] i);
      word_type v;
      case (i)
         3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/core/share_header_hash_target_check.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tdata = header_word, tuser = {stale_flag}, tlast
// rsp     | out       | rsp_tvalid/tready   | tdata = status (2 bits, zero-filled to 8)
// csr     | in        | csr_we              | csr_index selects target_q0..q3, csr_wdata
// A header word is written into the front queue, which holds four words.
// Word 16 starts a 64-round compression at one round per cycle;
// word 20 runs two compressions, a compare and a result state that holds until rsp is taken.
// Throughput is set by the single round unit; the engine takes no new word while it runs.
// Reset (synchronous, high) empties the queue and loads the initial hash values.
// A stalled rsp holds the engine; the front keeps taking words until the queue fills.
module share_header_hash_target_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] header_word
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] stale_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] status, [7:2] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [63:0]          target_ff [4];
   logic                 q_valid, q_ready;
   shht_pkg::entry_type  q_data;
   logic [1:0]           status;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) target_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            shht_pkg::CSR_TARGET_Q0: target_ff[0] <= csr_wdata;
            shht_pkg::CSR_TARGET_Q1: target_ff[1] <= csr_wdata;
            shht_pkg::CSR_TARGET_Q2: target_ff[2] <= csr_wdata;
            default:                 target_ff[3] <= csr_wdata;
         endcase
      end
   end

   shht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (req_tdata),
      .in_last  (req_tlast),
      .in_stale (req_tuser),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   shht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data),
      .target     ({target_ff[3], target_ff[2], target_ff[1], target_ff[0]}),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (status)
   );

   assign rsp_tdata = {6'd0, status};

endmodule

### rtl/core/shht_front.sv
module shht_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31:0]           in_word,
   input  logic                  in_last,
   input  logic                  in_stale,
   output logic                  q_valid,
   input  logic                  q_ready,
   output shht_pkg::entry_type   q_data
);

   shht_pkg::entry_type              mem_ff [shht_pkg::QDEPTH];
   logic [shht_pkg::QPTR_W:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [shht_pkg::CNT_W-1:0]       pos_ff, pos_in;
   shht_pkg::entry_type              ent;
   logic                             push, pop, full;

   assign full = (wr_ff[shht_pkg::QPTR_W] != rd_ff[shht_pkg::QPTR_W]) &&
                 (wr_ff[shht_pkg::QPTR_W-1:0] == rd_ff[shht_pkg::QPTR_W-1:0]);
   assign in_ready = !full;
   assign push = in_valid && in_ready;
   assign q_valid = (wr_ff != rd_ff);
   assign pop = q_valid && q_ready;
   assign q_data = mem_ff[rd_ff[shht_pkg::QPTR_W-1:0]];

   always_comb begin
      ent.word  = {in_word[7:0], in_word[15:8], in_word[23:16], in_word[31:24]};
      ent.pos   = pos_ff;
      ent.stale = in_stale;
      ent.abort = in_last &&
                  (pos_ff != shht_pkg::CNT_W'(shht_pkg::HDR_WORDS - 1));
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      pos_in = pos_ff;
      if (push) begin
         if (ent.abort || pos_ff == shht_pkg::CNT_W'(shht_pkg::HDR_WORDS - 1))
            pos_in = '0;
         else
            pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         pos_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         pos_ff <= pos_in;
      end
      if (push) mem_ff[wr_ff[shht_pkg::QPTR_W-1:0]] <= ent;
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < shht_pkg::CNT_W'(shht_pkg::HDR_WORDS)) else $error("pos out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      push && pos_ff == shht_pkg::CNT_W'(shht_pkg::HDR_WORDS - 1) |=> pos_ff == '0)
      else $error("position did not wrap");

endmodule

### rtl/core/shht_back.sv
module shht_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  shht_pkg::entry_type   q_data,
   input  logic [255:0]          target,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_ADD    = 5'b00100,
      ST_CMP    = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      w_ff [16];
   logic [31:0]      w_in [16];
   logic [31:0]      h_ff [8];
   logic [31:0]      h_in [8];
   logic [31:0]      v_ff [8];
   logic [31:0]      v_in [8];
   logic [5:0]       rnd_ff, rnd_in;
   logic             second_ff, second_in;   // running the digest-of-digest pass
   logic             final_ff, final_in;     // first pass is the last block of header
   logic             stale_ff, stale_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      t1, t2, s0, s1, wnew;
   logic [255:0]     hash_le;

   assign q_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_status = status_ff;

   always_comb begin
      s0 = shht_pkg::rotr(w_ff[1], 7) ^ shht_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = shht_pkg::rotr(w_ff[14], 17) ^ shht_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (shht_pkg::rotr(v_ff[4], 6) ^ shht_pkg::rotr(v_ff[4], 11) ^
                      shht_pkg::rotr(v_ff[4], 25)) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + shht_pkg::sha_k(rnd_ff) + w_ff[0];
      t2 = (shht_pkg::rotr(v_ff[0], 2) ^ shht_pkg::rotr(v_ff[0], 13) ^
            shht_pkg::rotr(v_ff[0], 22)) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      // digest byte k carries bits 8k..8k+7
      for (int i = 0; i < 8; i++)
         hash_le[i*32 +: 32] = {h_ff[i][7:0], h_ff[i][15:8], h_ff[i][23:16], h_ff[i][31:24]};
   end

   always_comb begin
      state_in = state_ff;
      w_in = w_ff;
      h_in = h_ff;
      v_in = v_ff;
      rnd_in = rnd_ff;
      second_in = second_ff;
      final_in = final_ff;
      stale_in = stale_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_data.abort) begin
                  for (int i = 0; i < 8; i++) h_in[i] = shht_pkg::sha_iv(3'(i));
               end else if (q_data.pos == shht_pkg::CNT_W'(shht_pkg::HDR_WORDS - 1)) begin
                  w_in[3] = q_data.word;
                  w_in[4] = 32'h80000000;
                  for (int i = 5; i < 15; i++) w_in[i] = '0;
                  w_in[15] = 32'(shht_pkg::HDR_WORDS * 32);
                  stale_in = q_data.stale;
                  final_in = 1'b1;
                  second_in = 1'b0;
                  v_in = h_ff;
                  rnd_in = '0;
                  state_in = ST_ROUND;
               end else begin
                  w_in[q_data.pos[3:0]] = q_data.word;
                  if (q_data.pos == shht_pkg::CNT_W'(15)) begin
                     final_in = 1'b0;
                     second_in = 1'b0;
                     v_in = h_ff;
                     rnd_in = '0;
                     state_in = ST_ROUND;
                  end
               end
            end
         end
         ST_ROUND: begin
            // shift the schedule window; w_ff[0] is always the current word
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
            w_in[15] = wnew;
            for (int i = 1; i < 8; i++) v_in[i] = v_ff[i-1];
            v_in[4] = v_ff[3] + t1;
            v_in[0] = t1 + t2;
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            state_in = ST_IDLE;
            if (final_ff && !second_ff) begin
               for (int i = 0; i < 8; i++) begin
                  w_in[i] = h_ff[i] + v_ff[i];
                  h_in[i] = shht_pkg::sha_iv(3'(i));
                  v_in[i] = shht_pkg::sha_iv(3'(i));
               end
               w_in[8] = 32'h80000000;
               for (int i = 9; i < 15; i++) w_in[i] = '0;
               w_in[15] = 32'd256;
               second_in = 1'b1;
               rnd_in = '0;
               state_in = ST_ROUND;
            end else if (second_ff) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            status_in = (hash_le > target) ? shht_pkg::STATUS_ABOVE :
                        (stale_ff ? shht_pkg::STATUS_STALE : shht_pkg::STATUS_ACCEPTED);
            for (int i = 0; i < 8; i++) h_in[i] = shht_pkg::sha_iv(3'(i));
            second_in = 1'b0;
            final_in = 1'b0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rnd_ff    <= '0;
         second_ff <= 1'b0;
         final_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= shht_pkg::sha_iv(3'(i));
      end else begin
         state_ff  <= state_in;
         rnd_ff    <= rnd_in;
         second_ff <= second_in;
         final_ff  <= final_in;
         h_ff      <= h_in;
      end
      w_ff      <= w_in;
      v_ff      <= v_in;
      stale_ff  <= stale_in;
      status_ff <= status_in;
   end

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> status_ff != 2'd3) else $error("bad status");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(status_ff)) else $error("result lost");
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && rnd_ff == 6'd63 |=> state_ff == ST_ADD)
      else $error("round count slip");
   a_second_only_final: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> final_ff) else $error("second pass without final block");

endmodule

### test/shht_checker.sv
module shht_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output int           fail_count,
   output int           pending,
   output logic [255:0] last_hash
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [63:0] target [4];
   logic [31:0] msg [16];
   logic [31:0] chain [8];
   int          word_pos;
   logic [1:0]  status_exp [$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of msg into chain
   function automatic void compress_msg();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = msg[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endfunction

   task automatic report(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic take_request(input logic [31:0] data, input logic mark, input logic stale);
      logic [31:0]  word;
      logic [255:0] hash_le;
      word = {data[7:0], data[15:8], data[23:16], data[31:24]};
      if (word_pos >= shht_pkg::HDR_WORDS - 1) begin
         msg[3] = word;
         msg[4] = 32'h80000000;
         for (int i = 5; i < 15; i++) msg[i] = '0;
         msg[15] = 32'(shht_pkg::HDR_WORDS * 32);
         compress_msg();
         for (int i = 0; i < 8; i++) msg[i] = chain[i];
         msg[8] = 32'h80000000;
         for (int i = 9; i < 15; i++) msg[i] = '0;
         msg[15] = 32'd256;
         chain = INIT_HASH;
         compress_msg();
         // digest byte k lands at bits 8k..8k+7
         for (int k = 0; k < 32; k++)
            hash_le[8*k +: 8] = 8'(chain[k >> 2] >> (24 - 8 * (k & 3)));
         last_hash = hash_le;
         if (hash_le > {target[3], target[2], target[1], target[0]})
            status_exp.push_back(shht_pkg::STATUS_ABOVE);
         else
            status_exp.push_back(stale ? shht_pkg::STATUS_STALE : shht_pkg::STATUS_ACCEPTED);
         chain = INIT_HASH;
         word_pos = 0;
      end else if (mark) begin
         chain = INIT_HASH;
         word_pos = 0;
      end else begin
         msg[word_pos & 15] = word;
         if (word_pos == 15) compress_msg();
         word_pos++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      last_hash = '0;
   end

   always @(posedge clock) begin
      logic [1:0] exp_status;
      if (reset) begin
         for (int i = 0; i < 4; i++) target[i] = '0;
         chain = INIT_HASH;
         word_pos = 0;
         status_exp.delete();
      end else begin
         if (csr_we) target[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) take_request(req_tdata, req_tlast, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (status_exp.size() == 0) begin
               report($sformatf("unexpected status %0d", rsp_tdata[1:0]));
            end else begin
               exp_status = status_exp.pop_front();
               if (rsp_tdata[1:0] !== exp_status)
                  report($sformatf("status %0d, want %0d", rsp_tdata[1:0], exp_status));
               if (rsp_tdata[7:2] !== '0)
                  report($sformatf("pad bits %b not zero", rsp_tdata[7:2]));
            end
         end
      end
      pending = status_exp.size();
   end

endmodule

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO = 1;
   localparam int FILL_ONES = 2;
   localparam int FILL_REPEAT = 3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = shht_pkg::CSR_TARGET_Q0;
   logic [63:0]  csr_wdata = '0;
   int           fail_count;
   int           pending;
   logic [255:0] last_hash;

   logic         req_taken;
   int           quiet_cycles = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           words_sent = 0;
   logic [31:0]  header [shht_pkg::HDR_WORDS];

   always #2 clock = ~clock;

   share_header_hash_target_check u_dut (.*);

   shht_checker u_chk (.*);

   always @(posedge clock) req_taken <= req_tvalid && req_tready;

   always @(negedge clock) rsp_tready = $urandom_range(99) >= stall_pct;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] data, input logic mark, input logic stale);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = data;
      req_tlast = mark;
      req_tuser = stale;
      req_tvalid = 1'b1;
      do @(negedge clock); while (!req_taken);
      words_sent++;
   endtask

   // length below the header size, with mark_end set, drops the share with an early last mark
   task automatic send_share(input int len, input logic mark_end, input int fill,
                             input logic stale);
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: header[i] = '0;
            FILL_ONES: header[i] = '1;
            FILL_RANDOM: header[i] = $urandom;
            default: ;
         endcase
         send_request(header[i], (i == len - 1) ? mark_end : 1'b0,
                      (i == len - 1) ? stale : 1'($urandom_range(1)));
      end
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      // a dropped share may still be in the engine
      repeat (200) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_target(input logic [255:0] t);
      write_reg(shht_pkg::CSR_TARGET_Q0, t[63:0]);
      write_reg(shht_pkg::CSR_TARGET_Q1, t[127:64]);
      write_reg(shht_pkg::CSR_TARGET_Q2, t[191:128]);
      write_reg(shht_pkg::CSR_TARGET_Q3, t[255:192]);
   endtask

   task automatic random_phase(input int words);
      int stop_at;
      int pick;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 80)
            send_share(shht_pkg::HDR_WORDS, 1'b1, FILL_RANDOM, 1'($urandom_range(1)));
         else if (pick < 90)
            send_share($urandom_range(shht_pkg::HDR_WORDS - 1, 1), 1'b1, FILL_RANDOM,
                       1'($urandom_range(1)));
         else
            send_share(shht_pkg::HDR_WORDS, 1'b0, FILL_RANDOM, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [255:0] rand_target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // target zero after reset: every hash is above
      send_share(shht_pkg::HDR_WORDS, 1'b1, FILL_ZERO, 1'b1);
      drain();
      set_target('1);
      send_share(shht_pkg::HDR_WORDS, 1'b1, FILL_ONES, 1'b1);
      send_share(shht_pkg::HDR_WORDS, 1'b1, FILL_RANDOM, 1'b0);
      send_share(1, 1'b1, FILL_RANDOM, 1'b0);
      send_share(shht_pkg::HDR_WORDS - 1, 1'b1, FILL_RANDOM, 1'b1);
      send_share(shht_pkg::HDR_WORDS, 1'b0, FILL_RANDOM, 1'b1);
      drain();
      // hash equal to target
      set_target(last_hash);
      send_share(shht_pkg::HDR_WORDS, 1'b0, FILL_REPEAT, 1'b0);
      send_share(shht_pkg::HDR_WORDS, 1'b1, FILL_REPEAT, 1'b1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 50; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 50; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         rand_target = {$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom};
         set_target(phase == 0 ? '1 : rand_target);
         random_phase(310);
         drain();
      end
      set_target('0);
      random_phase(40);
      drain();

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
